@@ rtl/core/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and constants for the URI percent decoder: classified
// item layout, decode modes, status codes and character constants.
// ----------------------------------------------------------------------------
package upd_pkg;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // escape character after reset ('%')
    localparam logic [7:0] ESC_RESET = 8'd37;

    // hex digit bounds
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LF = 8'h66;
    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UF = 8'h46;
    localparam logic [3:0] HEX_TEN = 4'hA;

    // decode modes
    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_DIGIT1,
        MODE_DIGIT2,
        MODE_DISCARD
    } mode_t;

    // end-of-string status codes
    typedef enum logic [1:0] {
        ST_OK,
        ST_TRUNC,
        ST_BADHEX,
        ST_ZERO
    } status_t;

    // one classified input item
    typedef struct packed {
        logic [7:0] raw;
        logic       is_esc;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       last;
    } item_t;

    // queue fill status
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

@@ rtl/core/upd_front.sv @@
// ----------------------------------------------------------------------------
// upd_front
// Input side: holds the escape character register, accepts items and
// classifies each byte as escape character and hex digit before queueing.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             in_byte,
    input  logic                   last_byte,
    input  upd_pkg::queue_status_t q_status,
    output logic                   push,
    output upd_pkg::item_t         push_item
);

    logic [7:0] esc_reg;
    logic [7:0] esc_next;
    logic       hex_ok;
    logic [3:0] hex_val;

    // escape character register
    always_comb
    begin
        esc_next = esc_reg;
        if (cfg_we)
        begin
            esc_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= upd_pkg::ESC_RESET;
        end
        else
        begin
            esc_reg <= esc_next;
        end
    end

    // hex digit value of the incoming byte
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = '0;
        if (in_byte inside {[upd_pkg::CHAR_0:upd_pkg::CHAR_9]})
        begin
            hex_val = 4'(in_byte - upd_pkg::CHAR_0);
        end
        else if (in_byte inside {[upd_pkg::CHAR_LA:upd_pkg::CHAR_LF]})
        begin
            hex_val = 4'(in_byte - upd_pkg::CHAR_LA) + upd_pkg::HEX_TEN;
        end
        else if (in_byte inside {[upd_pkg::CHAR_UA:upd_pkg::CHAR_UF]})
        begin
            hex_val = 4'(in_byte - upd_pkg::CHAR_UA) + upd_pkg::HEX_TEN;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    // classified item into the queue
    always_comb
    begin
        push_item.raw     = in_byte;
        push_item.is_esc  = (in_byte == esc_reg);
        push_item.hex_ok  = hex_ok;
        push_item.hex_val = hex_val;
        push_item.last    = last_byte;
    end

    // accept while the queue has room
    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

@@ rtl/core/upd_queue.sv @@
// ----------------------------------------------------------------------------
// upd_queue
// Small first-in first-out queue of classified items between the front
// and the back, so either side may stall without blocking the other.
// ----------------------------------------------------------------------------
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  upd_pkg::item_t         push_item,
    input  logic                   pop,
    output upd_pkg::item_t         head_item,
    output upd_pkg::queue_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upd_pkg::item_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item      = entry_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));

endmodule

@@ rtl/core/upd_back.sv @@
// ----------------------------------------------------------------------------
// upd_back
// Decode side: runs the escape state machine over queued items and
// holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  upd_pkg::item_t         head_item,
    input  upd_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             data_byte,
    output logic                   data_valid,
    output logic                   end_of_string,
    output logic [1:0]             status
);

    upd_pkg::mode_t   mode_reg;
    upd_pkg::mode_t   mode_next;
    logic [3:0]       nibble_reg;
    logic [3:0]       nibble_next;
    upd_pkg::status_t held_reg;
    upd_pkg::status_t held_next;

    // decode results for the head item
    upd_pkg::mode_t   step_mode;
    upd_pkg::status_t step_st;
    logic             have_data;
    logic [7:0]       step_data;
    logic [7:0]       decoded;

    logic             res_valid;
    logic [7:0]       res_data;
    logic [1:0]       res_status;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       data_byte_reg;
    logic             data_valid_reg;
    logic             eos_reg;
    logic [1:0]       status_reg;

    // take the head item when the output register is free or draining
    assign pop     = !q_status.empty && (!out_valid_reg || !out_stall);
    assign decoded = {nibble_reg, head_item.hex_val};

    // mode transition for one item
    always_comb
    begin
        step_mode   = mode_reg;
        step_st     = held_reg;
        nibble_next = nibble_reg;
        held_next   = held_reg;
        have_data   = 1'b0;
        step_data   = '0;
        case (mode_reg)
            upd_pkg::MODE_NORMAL:
            begin
                if (head_item.is_esc)
                begin
                    step_mode = upd_pkg::MODE_DIGIT1;
                    step_st   = upd_pkg::ST_TRUNC;
                end
                else
                begin
                    have_data = 1'b1;
                    step_data = head_item.raw;
                end
            end
            upd_pkg::MODE_DIGIT1:
            begin
                nibble_next = head_item.hex_val;
                held_next   = head_item.hex_ok ? upd_pkg::ST_OK : upd_pkg::ST_BADHEX;
                step_mode   = upd_pkg::MODE_DIGIT2;
                step_st     = upd_pkg::ST_TRUNC;
            end
            upd_pkg::MODE_DIGIT2:
            begin
                if (held_reg != upd_pkg::ST_OK || !head_item.hex_ok)
                begin
                    step_st   = upd_pkg::ST_BADHEX;
                    held_next = upd_pkg::ST_BADHEX;
                    step_mode = upd_pkg::MODE_DISCARD;
                end
                else if (decoded == 8'd0)
                begin
                    step_st   = upd_pkg::ST_ZERO;
                    held_next = upd_pkg::ST_ZERO;
                    step_mode = upd_pkg::MODE_DISCARD;
                end
                else
                begin
                    have_data = 1'b1;
                    step_data = decoded;
                    step_st   = upd_pkg::ST_OK;
                    step_mode = upd_pkg::MODE_NORMAL;
                end
            end
            default:
            begin
                step_st = held_reg;
            end
        endcase

        // end of string closes any escape and clears the state
        mode_next = step_mode;
        if (head_item.last)
        begin
            if (step_mode == upd_pkg::MODE_DIGIT1 || step_mode == upd_pkg::MODE_DIGIT2)
            begin
                step_st = upd_pkg::ST_TRUNC;
            end
            else if (step_mode == upd_pkg::MODE_NORMAL)
            begin
                step_st = upd_pkg::ST_OK;
            end
            mode_next   = upd_pkg::MODE_NORMAL;
            nibble_next = '0;
            held_next   = upd_pkg::ST_OK;
        end
    end

    // decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= upd_pkg::MODE_NORMAL;
            nibble_reg <= '0;
            held_reg   <= upd_pkg::ST_OK;
        end
        else if (pop)
        begin
            mode_reg   <= mode_next;
            nibble_reg <= nibble_next;
            held_reg   <= held_next;
        end
    end

    // result fields for the output register
    always_comb
    begin
        res_valid  = have_data || head_item.last;
        res_data   = have_data ? step_data : 8'd0;
        res_status = head_item.last ? 2'(step_st) : 2'(upd_pkg::ST_OK);
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (pop && res_valid)
        begin
            data_byte_reg  <= res_data;
            data_valid_reg <= have_data;
            eos_reg        <= head_item.last;
            status_reg     <= res_status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_byte     = data_byte_reg;
    assign data_valid    = data_valid_reg;
    assign end_of_string = eos_reg;
    assign status        = status_reg;

endmodule

@@ rtl/core/uri_percent_decoder.sv @@
// ----------------------------------------------------------------------------
// uri_percent_decoder
// Streaming URI percent decoder, one string byte per item.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock cycle and gives at most one result
// per byte, so it sustains one item per cycle when neither side stalls.
// A byte is classified at the input (escape character, hex digit) and
// placed in a QUEUE_DEPTH-entry queue; the decode state machine takes one
// queued byte per cycle while the output register is free or draining and
// writes its result to the output register; each byte is registered in a
// queue entry and its result in the output register. While a result waits
// on out_stall, input keeps flowing until the queue fills.
// Bytes that cause no result (escape characters, first digits, discarded
// bytes) still pass through the decode stage. Write cfg_data with
// cfg_we only while no string is in flight.
// ----------------------------------------------------------------------------
module uri_percent_decoder #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_byte,
    output logic       data_valid,
    output logic       end_of_string,
    output logic [1:0] status
);

    upd_pkg::queue_status_t q_status;
    upd_pkg::item_t         push_item;
    upd_pkg::item_t         head_item;
    logic                   push;
    logic                   pop;

    // input classification
    upd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    // item queue
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    // decode and output register
    upd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_item     (head_item),
        .q_status      (q_status),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .end_of_string (end_of_string),
        .status        (status)
    );

endmodule

@@ bench/uri_percent_decoder_test.sv @@
// ----------------------------------------------------------------------------
// uri_percent_decoder_test
// Self-checking bench for the streaming URI percent decoder. A behavioral
// decoder tracks every accepted byte and queues the result it should cause;
// each result taken from the block is checked field by field against the
// oldest queued one. Directed strings cover the escape corner cases, then
// random strings run under several escape characters and idle patterns.
// ----------------------------------------------------------------------------
module uri_percent_decoder_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = upd_pkg::QUEUE_DEPTH + 6;
    localparam int PHASE_BYTES   = 300;

    // one decoder result as seen on the output port
    typedef struct packed {
        logic [7:0]       data;
        logic             dv;
        logic             eos;
        upd_pkg::status_t st;
    } decoded_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       end_of_string;
    logic [1:0] status;

    // behavioral decoder state
    logic [7:0]       escape_setting;
    upd_pkg::mode_t   model_mode;
    logic [3:0]       model_nibble;
    upd_pkg::status_t model_held;

    decoded_t   pending_results[$];
    logic [7:0] str_buf[$];

    int send_idle_pct;
    int stall_pct;
    int failures;
    int cycle_count;
    int bytes_sent;
    int strings_sent;
    int results_checked;
    int escape_writes;
    int status_seen[4];

    uri_percent_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .end_of_string (end_of_string),
        .status        (status)
    );

    // clock
    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // random output stall
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // hex digit lookup: bit 4 set for a valid digit, low bits its value
    function automatic logic [4:0] hex_lookup(input logic [7:0] c);
        if (c >= upd_pkg::CHAR_0 && c <= upd_pkg::CHAR_9)
            return {1'b1, 4'(c - upd_pkg::CHAR_0)};
        if (c >= upd_pkg::CHAR_LA && c <= upd_pkg::CHAR_LF)
            return {1'b1, 4'(c - upd_pkg::CHAR_LA) + upd_pkg::HEX_TEN};
        if (c >= upd_pkg::CHAR_UA && c <= upd_pkg::CHAR_UF)
            return {1'b1, 4'(c - upd_pkg::CHAR_UA) + upd_pkg::HEX_TEN};
        return 5'd0;
    endfunction

    // hex digit character, letters in random case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < upd_pkg::HEX_TEN)
            return upd_pkg::CHAR_0 + 8'(v);
        if ($urandom_range(1) == 1)
            return upd_pkg::CHAR_LA + 8'(v - upd_pkg::HEX_TEN);
        return upd_pkg::CHAR_UA + 8'(v - upd_pkg::HEX_TEN);
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        logic [4:0] h;
        do
        begin
            c = 8'($urandom_range(255));
            h = hex_lookup(c);
        end
        while (h[4]);
        return c;
    endfunction

    // advance the behavioral decoder by one byte, queue its result if any
    task automatic decode_byte(input logic [7:0] b, input logic lst);
        logic             have;
        logic [7:0]       d;
        upd_pkg::status_t st;
        logic [4:0]       h;
        decoded_t         r;
        have = 1'b0;
        d    = 8'd0;
        st   = model_held;
        h    = hex_lookup(b);
        case (model_mode)
            upd_pkg::MODE_NORMAL:
            begin
                if (b == escape_setting)
                begin
                    model_mode = upd_pkg::MODE_DIGIT1;
                    st = upd_pkg::ST_TRUNC;
                end
                else
                begin
                    have = 1'b1;
                    d = b;
                end
            end
            upd_pkg::MODE_DIGIT1:
            begin
                model_nibble = h[3:0];
                model_held   = h[4] ? upd_pkg::ST_OK : upd_pkg::ST_BADHEX;
                model_mode   = upd_pkg::MODE_DIGIT2;
                st = upd_pkg::ST_TRUNC;
            end
            upd_pkg::MODE_DIGIT2:
            begin
                if (model_held != upd_pkg::ST_OK || !h[4])
                begin
                    st = upd_pkg::ST_BADHEX;
                    model_held = upd_pkg::ST_BADHEX;
                    model_mode = upd_pkg::MODE_DISCARD;
                end
                else if ({model_nibble, h[3:0]} == 8'd0)
                begin
                    st = upd_pkg::ST_ZERO;
                    model_held = upd_pkg::ST_ZERO;
                    model_mode = upd_pkg::MODE_DISCARD;
                end
                else
                begin
                    have = 1'b1;
                    d = {model_nibble, h[3:0]};
                    st = upd_pkg::ST_OK;
                    model_mode = upd_pkg::MODE_NORMAL;
                end
            end
            default:
                st = model_held;
        endcase

        // the end of a string reports and clears everything
        if (lst)
        begin
            if (model_mode == upd_pkg::MODE_DIGIT1 || model_mode == upd_pkg::MODE_DIGIT2)
                st = upd_pkg::ST_TRUNC;
            else if (model_mode == upd_pkg::MODE_NORMAL)
                st = upd_pkg::ST_OK;
            model_mode   = upd_pkg::MODE_NORMAL;
            model_nibble = 4'd0;
            model_held   = upd_pkg::ST_OK;
        end

        if (have || lst)
        begin
            r.data = have ? d : 8'd0;
            r.dv   = have;
            r.eos  = lst;
            r.st   = lst ? st : upd_pkg::ST_OK;
            pending_results.push_back(r);
        end
    endtask

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result data %h valid %b end %b status %0d",
                         $time, data_byte, data_valid, end_of_string, status);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.eos)
                    status_seen[want.st]++;
                if (data_byte !== want.data)
                begin
                    $display("%0t: data_byte expected %h actual %h",
                             $time, want.data, data_byte);
                    failures++;
                end
                if (data_valid !== want.dv)
                begin
                    $display("%0t: data_valid expected %b actual %b",
                             $time, want.dv, data_valid);
                    failures++;
                end
                if (end_of_string !== want.eos)
                begin
                    $display("%0t: end_of_string expected %b actual %b",
                             $time, want.eos, end_of_string);
                    failures++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, status);
                    failures++;
                end
            end
        end
    end

    // offer one item, with random idle cycles ahead of it; returns at acceptance
    task automatic send_item(input logic [7:0] b, input logic lst);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        last_byte <= lst;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(b, lst);
        bytes_sent++;
    endtask

    // drop valid and wait until every expected result has arrived
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // send str_buf as one string, optionally pausing for a full drain
    task automatic send_string(input bit allow_pause);
        for (int i = 0; i < str_buf.size(); i++)
        begin
            if (allow_pause && $urandom_range(39) == 0)
                drain_results();
            send_item(str_buf[i], i == str_buf.size() - 1);
        end
        strings_sent++;
    endtask

    // escape register write while the block is idle
    task automatic write_escape(input logic [7:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        escape_setting = v;
        escape_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random string: mostly plain bytes and well-formed escapes, some errors
    task automatic build_string();
        int         target;
        int         pick;
        logic [7:0] b;
        str_buf.delete();
        target = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(10, 1);
        while (str_buf.size() < target)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                b = 8'($urandom_range(255));
                if (b == escape_setting)
                    b = b ^ 8'h01;
                str_buf.push_back(b);
            end
            else if (pick < 80)
            begin
                str_buf.push_back(escape_setting);
                str_buf.push_back(hex_char(4'($urandom_range(15))));
                str_buf.push_back(hex_char(4'($urandom_range(15))));
            end
            else if (pick < 85)
            begin
                str_buf.push_back(escape_setting);
                str_buf.push_back(hex_char(4'd0));
                str_buf.push_back(hex_char(4'd0));
            end
            else if (pick < 92)
            begin
                str_buf.push_back(escape_setting);
                if ($urandom_range(1) == 1)
                begin
                    str_buf.push_back(non_hex_byte());
                    str_buf.push_back(hex_char(4'($urandom_range(15))));
                end
                else
                begin
                    str_buf.push_back(hex_char(4'($urandom_range(15))));
                    str_buf.push_back(non_hex_byte());
                end
            end
            else
                str_buf.push_back(8'($urandom_range(255)));
        end
        // now and then cut the string inside an escape
        if ($urandom_range(4) == 0)
            while (str_buf.size() > target)
                void'(str_buf.pop_back());
    endtask

    task automatic run_strings(input int count, input bit allow_pause);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count)
        begin
            build_string();
            send_string(allow_pause);
        end
    endtask

    // escape corner cases under the reset escape character
    task automatic test_directed_cases();
        str_buf = {8'h00, 8'hFF};
        send_string(1'b0);
        str_buf = {upd_pkg::ESC_RESET, "9", "f", upd_pkg::ESC_RESET, "F", "A"};
        send_string(1'b0);
        str_buf = {upd_pkg::ESC_RESET, "0", "0", "x"};
        send_string(1'b0);
        str_buf = {upd_pkg::ESC_RESET, "G", "1", "z"};
        send_string(1'b0);
        str_buf = {upd_pkg::ESC_RESET, "4", "G"};
        send_string(1'b0);
        str_buf = {upd_pkg::ESC_RESET};
        send_string(1'b0);
        str_buf = {upd_pkg::ESC_RESET, "G"};
        send_string(1'b0);
        str_buf = {upd_pkg::ESC_RESET, upd_pkg::ESC_RESET, "4", "1"};
        send_string(1'b0);
    endtask

    task automatic test_escape_extremes();
        write_escape(8'h00);
        run_strings(PHASE_BYTES, 1'b0);
        write_escape(8'hFF);
        run_strings(PHASE_BYTES, 1'b0);
    endtask

    task automatic test_random_escape();
        write_escape(8'($urandom_range(255)));
        run_strings(PHASE_BYTES, 1'b0);
    endtask

    task automatic test_default_escape();
        write_escape(upd_pkg::ESC_RESET);
        run_strings(PHASE_BYTES, 1'b0);
    endtask

    task automatic test_drain_pauses();
        write_escape(8'($urandom_range(255)));
        run_strings(PHASE_BYTES, 1'b1);
    endtask

    // test sequence
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = 8'd0;
        in_valid  = 1'b0;
        in_byte   = 8'd0;
        last_byte = 1'b0;

        escape_setting = upd_pkg::ESC_RESET;
        model_mode     = upd_pkg::MODE_NORMAL;
        model_nibble   = 4'd0;
        model_held     = upd_pkg::ST_OK;

        send_idle_pct = 0;
        stall_pct     = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender idles lightly, receiver stalls heavily
        send_idle_pct = 29;
        stall_pct     = 83;
        test_directed_cases();
        test_escape_extremes();

        // sender idles heavily, receiver stalls lightly
        send_idle_pct = 83;
        stall_pct     = 29;
        test_random_escape();
        test_default_escape();

        // full rate
        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_escape();
        test_drain_pauses();

        drain_results();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        $display("covered %0d bytes in %0d strings over %0d escape writes, %0d results checked",
                 bytes_sent, strings_sent, escape_writes, results_checked);
        $display("string ends: ok %0d, truncated %0d, bad hex %0d, zero byte %0d",
                 status_seen[upd_pkg::ST_OK], status_seen[upd_pkg::ST_TRUNC],
                 status_seen[upd_pkg::ST_BADHEX], status_seen[upd_pkg::ST_ZERO]);
        if (failures == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
